>>> sv/cyrtr_pkg.sv
// Shared types, constants and the Cyrillic pair table of the transliterator.
// No dependencies; used by every module of the block.
package cyrtr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_CHARS   = 4;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] UNDERSCORE = 8'h5f;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       terminator;
    } result_t;

    typedef logic [MAX_CHARS-1:0][7:0] chars_t;

    // one queued beat group: the characters of one item plus its terminator
    typedef struct packed {
        chars_t     chars;
        logic [2:0] count;
        logic       term;
    } job_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] count;
        chars_t     chars;
    } pair_map_t;

    function automatic pair_map_t mk(input logic [2:0] n, input logic [7:0] c0,
                                     input logic [7:0] c1, input logic [7:0] c2,
                                     input logic [7:0] c3);
        pair_map_t m;
        m.hit      = 1'b1;
        m.count    = n;
        m.chars[0] = c0;
        m.chars[1] = c1;
        m.chars[2] = c2;
        m.chars[3] = c3;
        return m;
    endfunction

    function automatic pair_map_t pair_lookup(input logic [7:0] lead, input logic [7:0] trail);
        pair_map_t m;
        m = '0;
        case ({lead, trail})
            16'hd099: m = mk(3'd1, "Y", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b9: m = mk(3'd1, "y", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a6: m = mk(3'd2, "T", "s", NUL_CHAR, NUL_CHAR);
            16'hd186: m = mk(3'd2, "t", "s", NUL_CHAR, NUL_CHAR);
            16'hd0a3: m = mk(3'd1, "U", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd183: m = mk(3'd1, "u", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09a: m = mk(3'd1, "K", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0ba: m = mk(3'd1, "k", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd095: m = mk(3'd1, "E", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b5: m = mk(3'd1, "e", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09d: m = mk(3'd1, "N", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0bd: m = mk(3'd1, "n", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd093: m = mk(3'd1, "G", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b3: m = mk(3'd1, "g", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a8: m = mk(3'd2, "S", "h", NUL_CHAR, NUL_CHAR);
            16'hd188: m = mk(3'd2, "s", "h", NUL_CHAR, NUL_CHAR);
            16'hd0a9: m = mk(3'd4, "S", "h", "c", "h");
            16'hd189: m = mk(3'd4, "s", "h", "c", "h");
            16'hd097: m = mk(3'd1, "Z", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b7: m = mk(3'd1, "z", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a5: m = mk(3'd2, "K", "h", NUL_CHAR, NUL_CHAR);
            16'hd185: m = mk(3'd2, "k", "h", NUL_CHAR, NUL_CHAR);
            16'hd0aa: m = mk(3'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd18a: m = mk(3'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd081: m = mk(3'd1, "E", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd191: m = mk(3'd1, "e", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a4: m = mk(3'd1, "F", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd184: m = mk(3'd1, "f", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0ab: m = mk(3'd1, "Y", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd18b: m = mk(3'd1, "y", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd092: m = mk(3'd1, "V", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b2: m = mk(3'd1, "v", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd090: m = mk(3'd1, "A", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b0: m = mk(3'd1, "a", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09f: m = mk(3'd1, "P", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0bf: m = mk(3'd1, "p", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a0: m = mk(3'd1, "R", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd180: m = mk(3'd1, "r", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09e: m = mk(3'd1, "O", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0be: m = mk(3'd1, "o", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09b: m = mk(3'd1, "L", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0bb: m = mk(3'd1, "l", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd094: m = mk(3'd1, "D", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b4: m = mk(3'd1, "d", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd096: m = mk(3'd2, "Z", "h", NUL_CHAR, NUL_CHAR);
            16'hd0b6: m = mk(3'd2, "z", "h", NUL_CHAR, NUL_CHAR);
            16'hd0ad: m = mk(3'd1, "E", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd18d: m = mk(3'd1, "e", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0af: m = mk(3'd2, "Y", "a", NUL_CHAR, NUL_CHAR);
            16'hd18f: m = mk(3'd2, "y", "a", NUL_CHAR, NUL_CHAR);
            16'hd0a7: m = mk(3'd2, "C", "h", NUL_CHAR, NUL_CHAR);
            16'hd187: m = mk(3'd2, "c", "h", NUL_CHAR, NUL_CHAR);
            16'hd0a1: m = mk(3'd1, "S", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd181: m = mk(3'd1, "s", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd09c: m = mk(3'd1, "M", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0bc: m = mk(3'd1, "m", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd098: m = mk(3'd1, "I", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b8: m = mk(3'd1, "i", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0a2: m = mk(3'd1, "T", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd182: m = mk(3'd1, "t", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0ac: m = mk(3'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd18c: m = mk(3'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd091: m = mk(3'd1, "B", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0b1: m = mk(3'd1, "b", NUL_CHAR, NUL_CHAR, NUL_CHAR);
            16'hd0ae: m = mk(3'd2, "Y", "u", NUL_CHAR, NUL_CHAR);
            16'hd18e: m = mk(3'd2, "y", "u", NUL_CHAR, NUL_CHAR);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> sv/cyrillic_utf8_transliterator_unit.sv
// Cyrillic UTF-8 to Latin transliterator, top level.
// Depends on cyrtr_pkg, cyrtr_front, cyrtr_queue, cyrtr_back.
//
// Input channel: push/full with item (in_byte, end_of_text); a byte is taken
// on a clock edge with push high and full low. Output channel: empty/pop with
// result (out_char, run_last, terminator); the head beat is valid while empty
// is low and is consumed on an edge with pop high.
// A byte is classified in its accept cycle and queued as a job of 0 to 4
// characters plus an optional terminator; jobs with no output are not queued.
// The first beat of an item is visible once its job is written into the queue
// and then loaded into the output stage register. Throughput: one byte per
// cycle while full is low and one beat per cycle while jobs wait and pop is
// high; each beat needs a pop, so the output beat rate bounds the input rate.
// When the receiver stalls, jobs accumulate in the QUEUE_DEPTH-entry queue and
// full rises once it fills; nothing is dropped.
// Reset clears the pending lead byte, the queue and the output stage; no
// clearing pass is needed.
module cyrillic_utf8_transliterator_unit #(
    parameter int QUEUE_DEPTH = cyrtr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cyrtr_pkg::item_t   item,
    output logic               empty,
    input  logic               pop,
    output cyrtr_pkg::result_t result
);

    logic            q_full, q_empty, q_pop, job_push;
    cyrtr_pkg::job_t job, q_data;

    cyrtr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job      (job)
    );

    cyrtr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    cyrtr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.terminator) |-> (result.run_last && result.out_char == 8'h00))
        else $error("terminator beat not last or nonzero");

    a_back_refills: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !q_empty) |=> !empty)
        else $error("output stage idle while jobs are queued");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !job_push)
        else $error("job pushed into a full queue");

endmodule

>>> sv/cyrtr_front.sv
// Front end: accepts input bytes, tracks the pending lead byte, classifies
// each item into a job of 0-4 characters plus an optional terminator. Uses cyrtr_pkg.
module cyrtr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cyrtr_pkg::item_t   item,
    input  logic               q_full,
    output logic               full,
    output logic               job_push,
    output cyrtr_pkg::job_t    job
);

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       accept;
    cyrtr_pkg::pair_map_t pm;

    function automatic logic is_passed(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "_";
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;
    assign pm     = cyrtr_pkg::pair_lookup(held_byte_reg, item.in_byte);

    always_comb
    begin
        job             = '0;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        if (accept)
        begin
            held_valid_next = 1'b0;
            if (held_valid_reg && pm.hit)
            begin
                job.chars = pm.chars;
                job.count = pm.count;
            end
            else if (is_passed(item.in_byte))
            begin
                job.chars[0] = item.in_byte;
                job.count    = 3'd1;
            end
            else if (item.in_byte == cyrtr_pkg::SPACE_CHAR)
            begin
                job.chars[0] = cyrtr_pkg::UNDERSCORE;
                job.count    = 3'd1;
            end
            else
            begin
                held_valid_next = 1'b1;
                held_byte_next  = item.in_byte;
            end
            if (item.end_of_text)
            begin
                held_valid_next = 1'b0;
                job.term        = 1'b1;
            end
        end
    end

    assign job_push = accept && (job.count != 3'd0 || job.term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
        end
    end

endmodule

>>> sv/cyrtr_queue.sv
// Short job queue between front and back ends.
// Uses cyrtr_pkg for the job type.
module cyrtr_queue #(
    parameter int DEPTH = cyrtr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  cyrtr_pkg::job_t  wr_data,
    input  logic             rd_en,
    output cyrtr_pkg::job_t  rd_data,
    output logic             q_full,
    output logic             q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cyrtr_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> sv/cyrtr_back.sv
// Back end: expands one queued job into output beats, one per pop.
// Uses cyrtr_pkg for job and result types.
module cyrtr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cyrtr_pkg::job_t    q_data,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output cyrtr_pkg::result_t result
);

    cyrtr_pkg::job_t job_reg, job_next;
    logic            valid_reg, valid_next;
    logic [2:0]      idx_reg, idx_next;
    logic [2:0]      total;
    logic            last;
    logic            load;

    assign total = job_reg.count + {2'b00, job_reg.term};
    assign last  = (3'(idx_reg + 3'd1) == total);
    assign empty = !valid_reg;
    assign load  = !q_empty && (!valid_reg || (pop && last));
    assign q_pop = load;

    always_comb
    begin
        result.run_last = last;
        if (idx_reg < job_reg.count)
        begin
            result.out_char   = job_reg.chars[idx_reg[1:0]];
            result.terminator = 1'b0;
        end
        else
        begin
            result.out_char   = cyrtr_pkg::NUL_CHAR;
            result.terminator = 1'b1;
        end
    end

    always_comb
    begin
        job_next   = job_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            job_next   = q_data;
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (pop && valid_reg)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = 3'(idx_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule
